// File: design/euclidean_signed_divider_defines.svh
// assertion macros for the euclidean signed divider
`ifndef EUCLIDEAN_SIGNED_DIVIDER_DEFINES_SVH
`define EUCLIDEAN_SIGNED_DIVIDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ESD_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ESD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ESD_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ESD_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// File: design/esd_pkg.sv
`default_nettype none
package esd_pkg;

   localparam int DATA_WIDTH = 32;

   // one item in flight through the cell chain
   typedef struct packed {
      logic                  valid;
      logic                  n_neg;
      logic                  d_neg;
      logic                  zero;
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] num;
      logic [DATA_WIDTH-1:0] div;
   } stage_type;

endpackage
`default_nettype wire

// File: design/esd_cell.sv
`default_nettype none
module esd_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  esd_pkg::stage_type prev_stage,
   output esd_pkg::stage_type next_stage
);
   import esd_pkg::*;

   stage_type             stage_ff;
   stage_type             stage_in;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   trial;
   logic                  qbit;

   // one restoring step: shift in the next dividend bit, try a subtract
   always_comb begin
      shifted  = {prev_stage.rem[DATA_WIDTH-2:0], prev_stage.num[DATA_WIDTH-1]};
      trial    = {1'b0, shifted} - {1'b0, prev_stage.div};
      qbit     = ~trial[DATA_WIDTH];
      stage_in = prev_stage;
      stage_in.rem = qbit ? trial[DATA_WIDTH-1:0] : shifted;
      stage_in.num = {prev_stage.num[DATA_WIDTH-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule
`default_nettype wire

// File: design/esd_fix.sv
`default_nettype none
module esd_fix (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  esd_pkg::stage_type prev_stage,
   output esd_pkg::stage_type next_stage
);
   import esd_pkg::*;

   stage_type stage_ff;
   stage_type stage_in;
   logic      adjust;

   // negative dividend with a nonzero raw remainder: bump magnitude, flip remainder
   always_comb begin
      adjust   = prev_stage.n_neg && (prev_stage.rem != '0);
      stage_in = prev_stage;
      stage_in.num = prev_stage.num + {{(DATA_WIDTH-1){1'b0}}, adjust};
      stage_in.rem = adjust ? (prev_stage.div - prev_stage.rem) : prev_stage.rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule
`default_nettype wire

// File: design/euclidean_signed_divider.sv
// Euclidean signed divider: quotient and a remainder that is always 0 .. |divisor|-1.
// Operands are taken as magnitudes through an entry register, then run down a chain
// of DATA_WIDTH identical restoring cells, one quotient bit per cell, then a fix-up
// stage (negative dividend correction) and the result register. The chain holds one
// item per cell, so a new beat can be taken every cycle unless a finished response
// beat is held stalled at the output: a stalled valid response freezes the whole
// chain and raises req_stall. A zero divisor gives zero_divisor with zero quotient
// and remainder; the most negative numerator over -1 gives quotient_overflow with
// zero quotient.
`default_nettype none
`include "euclidean_signed_divider_defines.svh"
module euclidean_signed_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [esd_pkg::DATA_WIDTH-1:0] req_numerator,
   input  logic signed [esd_pkg::DATA_WIDTH-1:0] req_divisor,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [esd_pkg::DATA_WIDTH-1:0] rsp_quotient,
   output logic        [esd_pkg::DATA_WIDTH-2:0] rsp_remainder,
   output logic                                 rsp_zero_divisor,
   output logic                                 rsp_quotient_overflow
);
   import esd_pkg::*;

   logic rsp_valid_ff;

   // whole chain moves together unless a finished beat is held at the output
   logic advance;
   assign advance   = ~(rsp_valid_ff && rsp_stall);
   assign req_stall = ~advance;

   // entry stage: sign split and magnitudes
   stage_type entry_ff;
   stage_type entry_in;

   always_comb begin
      entry_in.valid = req_valid;
      entry_in.n_neg = req_numerator[DATA_WIDTH-1];
      entry_in.d_neg = req_divisor[DATA_WIDTH-1];
      entry_in.zero  = (req_divisor == '0);
      // two's complement negate; most negative value maps to 2^(w-1) as unsigned
      entry_in.num   = req_numerator[DATA_WIDTH-1] ? (~req_numerator + 1'b1)
                                                   : req_numerator;
      entry_in.div   = req_divisor[DATA_WIDTH-1] ? (~req_divisor + 1'b1) : req_divisor;
      entry_in.rem   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   // restoring cell chain, one quotient bit per cell
   stage_type chain [DATA_WIDTH+1];
   assign chain[0] = entry_ff;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      esd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_stage (chain[i]),
         .next_stage (chain[i+1])
      );
   end

   // euclidean correction for negative dividends
   stage_type fix_stage;

   esd_fix u_fix (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .prev_stage (chain[DATA_WIDTH]),
      .next_stage (fix_stage)
   );

   // sign and overflow of the final quotient
   logic                  q_neg;
   logic                  ovf;
   logic [DATA_WIDTH-1:0] quotient_in;
   logic [DATA_WIDTH-2:0] remainder_in;
   logic                  zero_in;
   logic                  ovf_in;

   always_comb begin
      q_neg = (fix_stage.n_neg ^ fix_stage.d_neg) && (fix_stage.num != '0);
      // positive result must stay below 2^(w-1), negative may reach it exactly
      if (q_neg) begin
         ovf = fix_stage.num[DATA_WIDTH-1] && (fix_stage.num[DATA_WIDTH-2:0] != '0);
      end else begin
         ovf = fix_stage.num[DATA_WIDTH-1];
      end
      if (fix_stage.zero) begin
         quotient_in  = '0;
         remainder_in = '0;
         zero_in      = 1'b1;
         ovf_in       = 1'b0;
      end else begin
         if (ovf) begin
            quotient_in = '0;
         end else if (q_neg) begin
            quotient_in = ~fix_stage.num + 1'b1;
         end else begin
            quotient_in = fix_stage.num;
         end
         remainder_in = fix_stage.rem[DATA_WIDTH-2:0];
         zero_in      = 1'b0;
         ovf_in       = ovf;
      end
   end

   // result register
   logic [DATA_WIDTH-1:0] rsp_quotient_ff;
   logic [DATA_WIDTH-2:0] rsp_remainder_ff;
   logic                  rsp_zero_ff;
   logic                  rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fix_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_quotient_ff  <= quotient_in;
         rsp_remainder_ff <= remainder_in;
         rsp_zero_ff      <= zero_in;
         rsp_ovf_ff       <= ovf_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_quotient          = rsp_quotient_ff;
   assign rsp_remainder         = rsp_remainder_ff;
   assign rsp_zero_divisor      = rsp_zero_ff;
   assign rsp_quotient_overflow = rsp_ovf_ff;

   // a zero divisor beat carries nothing else
   `ESD_ASSERT_IMPLIES(a_zero_clean, clock, reset, rsp_valid && rsp_zero_divisor, (rsp_quotient == '0) && (rsp_remainder == '0) && !rsp_quotient_overflow)
   // an overflowed quotient reads as zero and is never a zero-divisor case
   `ESD_ASSERT_IMPLIES(a_ovf_clean, clock, reset, rsp_valid && rsp_quotient_overflow, (rsp_quotient == '0) && !rsp_zero_divisor)
   // a finished item in the fix-up stage reaches the output once the chain moves
   `ESD_ASSERT_NEXT(a_fix_to_out, clock, reset, fix_stage.valid && advance, rsp_valid)

endmodule
`default_nettype wire

// File: test/euclidean_signed_divider_tb.sv
module euclidean_signed_divider_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = esd_pkg::DATA_WIDTH;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};
   // cycles with no beat on either side before the run is declared hung
   localparam int HANG_LIMIT = 2000;
   // beats at the tail of the run that go through with no idling at all
   localparam int CALM_TAIL = 60;
   // extra cycles after the last response beat, a bit over the pipeline depth
   localparam int TAIL_CYCLES = W + 10;

   // one request beat, plus a flag that holds it back until the pipe drains
   typedef struct {
      logic signed [W-1:0] numerator;
      logic signed [W-1:0] divisor;
      bit                  drain_first;
   } div_request;

   typedef struct {
      logic signed [W-1:0] quotient;
      logic        [W-2:0] remainder;
      logic                zero_divisor;
      logic                quotient_overflow;
   } div_answer;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [W-1:0] req_numerator = '0;
   logic signed [W-1:0] req_divisor = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [W-1:0] rsp_quotient;
   logic        [W-2:0] rsp_remainder;
   logic                rsp_zero_divisor;
   logic                rsp_quotient_overflow;

   div_request pending_requests[$];
   div_answer  expected_answers[$];
   logic       req_taken = 1'b0;
   int         mismatch_count = 0;
   int         req_idle_left = 0;
   int         rsp_stall_left = 0;
   int         quiet_cycles = 0;

   euclidean_signed_divider DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_numerator         (req_numerator),
      .req_divisor           (req_divisor),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_quotient          (rsp_quotient),
      .rsp_remainder         (rsp_remainder),
      .rsp_zero_divisor      (rsp_zero_divisor),
      .rsp_quotient_overflow (rsp_quotient_overflow)
   );

   always #4 clock = ~clock;

   // euclidean division on magnitudes: remainder always lands in 0 .. |divisor|-1
   function automatic div_answer divide_euclid(input logic signed [W-1:0] num,
                                               input logic signed [W-1:0] den);
      div_answer   ans;
      logic [W-1:0] mag_n;
      logic [W-1:0] mag_d;
      logic [W-1:0] mag_q;
      logic [W-1:0] mag_r;
      logic [W-1:0] q_limit;
      logic         q_neg;
      logic         ovf;
      ans.quotient = '0;
      ans.remainder = '0;
      ans.zero_divisor = 1'b0;
      ans.quotient_overflow = 1'b0;
      if (den == '0) begin
         ans.zero_divisor = 1'b1;
         return ans;
      end
      // two's complement negate gives the exact magnitude, most negative included
      mag_n = num;
      if (num[W-1]) mag_n = ~mag_n + 1'b1;
      mag_d = den;
      if (den[W-1]) mag_d = ~mag_d + 1'b1;
      mag_q = mag_n / mag_d;
      mag_r = mag_n % mag_d;
      q_neg = num[W-1];
      // negative dividend with a leftover: step the quotient away from zero
      if (num[W-1] && mag_r != '0) begin
         mag_q = mag_q + 1'b1;
         mag_r = mag_d - mag_r;
      end
      if (den[W-1]) q_neg = ~q_neg;
      if (mag_q == '0) q_neg = 1'b0;
      q_limit = q_neg ? MOST_NEG : MOST_POS;
      ovf = mag_q > q_limit;
      ans.quotient_overflow = ovf;
      if (!ovf) ans.quotient = q_neg ? ~mag_q + 1'b1 : mag_q;
      ans.remainder = mag_r[W-2:0];
      return ans;
   endfunction

   // operand shapes: full range, small signed, edge values
   function automatic logic signed [W-1:0] pick_operand(input int shape);
      logic signed [W-1:0] val;
      case (shape)
         0: begin
            val = W'({$urandom, $urandom});
         end
         1: begin
            val = $urandom_range(0, 40);
            if ($urandom_range(0, 1) == 1) val = -val;
         end
         default: begin
            case ($urandom_range(0, 5))
               0: val = MOST_NEG;
               1: val = MOST_POS;
               2: val = MINUS_ONE;
               3: val = 1;
               4: val = MOST_NEG + 1;
               default: val = '0;
            endcase
         end
      endcase
      return val;
   endfunction

   task automatic queue_request(input logic signed [W-1:0] num,
                                input logic signed [W-1:0] den,
                                input bit drain_first);
      div_request item;
      item.numerator = num;
      item.divisor = den;
      item.drain_first = drain_first;
      pending_requests.push_back(item);
   endtask

   // request driver: changes on the falling edge, holds a beat until it is taken
   always @(negedge clock) begin
      div_request item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // beat still stalled, payload stays put
      end else if (req_idle_left > 0) begin
         req_valid <= 1'b0;
         req_idle_left = req_idle_left - 1;
      end else if (pending_requests.size() == 0) begin
         req_valid <= 1'b0;
      end else if (pending_requests[0].drain_first && expected_answers.size() != 0) begin
         // hold off until every response beat in flight is back
         req_valid <= 1'b0;
      end else if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
         // idle burst
         req_valid <= 1'b0;
         req_idle_left = $urandom_range(0, 2);
      end else begin
         item = pending_requests.pop_front();
         req_valid <= 1'b1;
         req_numerator <= item.numerator;
         req_divisor <= item.divisor;
      end
   end

   // response stall: random bursts, none near the end
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_stall_left = rsp_stall_left - 1;
      end else if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 6) == 0) begin
         rsp_stall <= 1'b1;
         rsp_stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predicts on each request beat, checks each response beat in order
   always @(posedge clock) begin
      div_answer want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_answers.push_back(divide_euclid(req_numerator, req_divisor));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            $error("response beat with no request waiting for it");
            mismatch_count = mismatch_count + 1;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_quotient !== want.quotient) begin
               $error("quotient: expected %0d, got %0d", want.quotient, rsp_quotient);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_remainder !== want.remainder) begin
               $error("remainder: expected %0d, got %0d", want.remainder, rsp_remainder);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_zero_divisor !== want.zero_divisor) begin
               $error("zero_divisor: expected %0b, got %0b",
                      want.zero_divisor, rsp_zero_divisor);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_quotient_overflow !== want.quotient_overflow) begin
               $error("quotient_overflow: expected %0b, got %0b",
                      want.quotient_overflow, rsp_quotient_overflow);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // watchdog: too long without any beat means the block is hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      int shape;
      logic signed [W-1:0] den;
      // directed: sign combinations, zero divisor, zero dividend, edge values
      queue_request(0, 0, 1'b0);
      queue_request(5, 0, 1'b0);
      queue_request(MOST_NEG, 0, 1'b0);
      queue_request(7, 2, 1'b0);
      queue_request(-7, 2, 1'b0);
      queue_request(7, -2, 1'b0);
      queue_request(-7, -2, 1'b0);
      queue_request(-8, 2, 1'b0);
      queue_request(-8, -2, 1'b0);
      queue_request(0, 5, 1'b0);
      queue_request(0, -5, 1'b0);
      // most negative over minus one does not fit
      queue_request(MOST_NEG, MINUS_ONE, 1'b0);
      queue_request(MOST_NEG, 1, 1'b0);
      queue_request(MOST_NEG, MOST_NEG, 1'b0);
      queue_request(MOST_POS, MOST_POS, 1'b0);
      queue_request(MOST_POS, MOST_NEG, 1'b0);
      queue_request(MOST_NEG, MOST_POS, 1'b0);
      queue_request(MOST_POS, 1, 1'b0);
      queue_request(MOST_POS, MINUS_ONE, 1'b0);
      queue_request(MINUS_ONE, MOST_NEG, 1'b0);
      queue_request(1, MOST_NEG, 1'b0);
      queue_request(MINUS_ONE, MOST_POS, 1'b0);
      queue_request(MOST_NEG, 2, 1'b0);
      queue_request(3, 7, 1'b0);
      queue_request(-3, 7, 1'b0);

      // random mix; two beats wait for an empty pipe first
      for (int i = 0; i < 450; i++) begin
         shape = $urandom_range(0, 9);
         if (shape < 5) begin
            queue_request(pick_operand(0), pick_operand(0), i == 0 || i == 250);
         end else if (shape < 7) begin
            queue_request(pick_operand($urandom_range(0, 1)), pick_operand(1),
                          i == 0 || i == 250);
         end else if (shape == 7) begin
            queue_request(pick_operand($urandom_range(0, 2)), 0, i == 0 || i == 250);
         end else if (shape == 8) begin
            queue_request(pick_operand($urandom_range(0, 2)),
                          pick_operand($urandom_range(0, 2)), i == 0 || i == 250);
         end else begin
            // exact multiple, remainder zero on every sign combination
            den = pick_operand(1);
            if (den == 0) den = 3;
            queue_request(den * pick_operand(1), den, i == 0 || i == 250);
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
